// ----- rtl/lsps_pkg.sv -----
// Package for the line sensor steering block: widths, codes and weight tables.
// No dependencies; used by the top level and by the port checker.
package lsps_pkg;
    localparam int CHANNELS    = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int CH_BITS     = 4;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_SAMPLE = 1'b1;
    localparam logic [1:0] MODE_TRACE   = 2'd0;
    localparam logic [1:0] MODE_LIMITED = 2'd1;
    localparam logic [1:0] MODE_BRIDGE_A = 2'd2;
    localparam logic [1:0] MODE_BRIDGE_B = 2'd3;
    localparam logic       CFG_LIMIT = 1'b0;
    localparam logic       CFG_SCALE = 1'b1;

    function automatic logic signed [3:0] weight(input logic [1:0] mode,
                                                 input logic [CH_BITS-1:0] ch);
        logic signed [3:0] w;
        begin
            w = 4'sd0;
            unique case (mode)
                MODE_BRIDGE_A:
                begin
                    case (ch)
                        4'd0: w = 4'sd1;   4'd1: w = 4'sd2;   4'd2: w = 4'sd3;
                        4'd3: w = 4'sd4;   4'd4: w = 4'sd5;   4'd5: w = 4'sd6;
                        4'd6: w = -4'sd6;  4'd7: w = -4'sd5;  4'd8: w = -4'sd4;
                        4'd9: w = -4'sd3;  4'd10: w = -4'sd2; 4'd11: w = -4'sd1;
                        default: w = 4'sd0;
                    endcase
                end
                MODE_BRIDGE_B:
                begin
                    case (ch)
                        4'd0, 4'd1, 4'd2, 4'd3: w = 4'sd2;
                        4'd4, 4'd5: w = 4'sd3;
                        4'd6, 4'd7: w = -4'sd3;
                        4'd8, 4'd9, 4'd10, 4'd11: w = -4'sd2;
                        default: w = 4'sd0;
                    endcase
                end
                default:
                begin
                    case (ch)
                        4'd0: w = 4'sd3;   4'd1: w = 4'sd5;   4'd2: w = 4'sd4;
                        4'd3: w = 4'sd3;   4'd4: w = 4'sd2;   4'd5: w = 4'sd1;
                        4'd6: w = -4'sd1;  4'd7: w = -4'sd2;  4'd8: w = -4'sd3;
                        4'd9: w = -4'sd4;  4'd10: w = -4'sd5; 4'd11: w = -4'sd3;
                        default: w = 4'sd0;
                    endcase
                end
            endcase
            return w;
        end
    endfunction
endpackage

// ----- rtl/line_sensor_pd_steering_top.sv -----
// Top level of the twelve-channel line sensor steering block with PD control.
// Depends on lsps_pkg for widths, codes and weights.
// Loads and samples on other channels do not make the block busy. A sample on channel 11 holds busy
// through a 12-step channel walk, scaling, a 53-step restoring divider, saturation, two multiply
// steps and the correction; division and saturation are skipped when the error is zeroed.
// The one-cycle result strobe follows busy; a new transaction may be accepted in that cycle.
// The receiver cannot stall. Reset clears the sequencer, the previous error and the
// registers to 20 and 3000.
module line_sensor_pd_steering_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [3:0]  channel,
    input  logic [11:0] raw_reading,
    input  logic [11:0] filtered_reading,
    input  logic [11:0] line_threshold,
    input  logic [11:0] white_threshold,
    input  logic [11:0] green_threshold,
    input  logic [7:0]  base_speed,
    input  logic [1:0]  steer_mode,
    input  logic [15:0] prop_gain,
    input  logic [15:0] deriv_gain,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [8:0]  right_speed,
    output logic [8:0]  left_speed,
    output logic signed [31:0] steer_error
);
    localparam int SB = lsps_pkg::SAMPLE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_WALK, S_SCALE, S_DIV, S_MULP, S_MULD, S_CORR, S_OUT
    } state_t;

    logic [SB-1:0] line_mem  [lsps_pkg::CHANNELS];
    logic [SB-1:0] white_mem [lsps_pkg::CHANNELS];
    logic [SB-1:0] green_mem [lsps_pkg::CHANNELS];
    logic [SB-1:0] raw_mem   [lsps_pkg::CHANNELS];
    logic [SB-1:0] filt_mem  [lsps_pkg::CHANNELS];

    state_t state_reg;
    logic [7:0]  limit_reg;
    logic [15:0] scale_reg;
    logic signed [31:0] prev_err_reg;
    logic [3:0]  ch_reg;
    logic [5:0]  step_reg;
    logic [7:0]  speed_reg;
    logic [1:0]  mode_reg;
    logic [15:0] kp_reg, kd_reg;
    logic signed [19:0] gsum_reg;
    logic [15:0] fsum_reg;
    logic [1:0]  cnt_reg;
    logic [11:0] white_reg;
    logic        allg_reg;
    logic        neg_reg;
    logic [52:0] num_reg;
    logic [16:0] rem_reg;
    logic [52:0] quo_reg;
    logic signed [31:0] err_reg;
    logic signed [55:0] acc_reg;
    logic signed [31:0] corr_reg;

    logic accept;
    assign accept = start && !busy;

    logic [SB-1:0] rd_raw, rd_filt, rd_line, rd_white, rd_green;
    logic signed [3:0] wt;
    logic signed [19:0] prod_w;
    logic zeroed;
    logic mid;
    logic [16:0] rem_sh;
    logic [17:0] rem_try;
    logic [31:0] sat_mag;
    logic signed [32:0] derr;
    logic signed [55:0] mul_p, mul_d, corr_div;
    logic signed [31:0] corr_lim;
    logic [11:0] cap_n10;
    logic [15:0] cap_n100;
    logic [27:0] cap_p10, cap_p100;
    logic [10:0] cap;
    logic signed [33:0] rs, ls;

    always_comb
    begin
        rd_raw   = raw_mem[ch_reg];
        rd_filt  = filt_mem[ch_reg];
        rd_line  = line_mem[ch_reg];
        rd_white = white_mem[ch_reg];
        rd_green = green_mem[ch_reg];
        wt       = lsps_pkg::weight(mode_reg, ch_reg);
        prod_w   = 20'(wt) * $signed({8'd0, rd_raw});
        mid = white_reg[5] || white_reg[6];
        zeroed = (&white_reg[10:1]) || allg_reg || (white_reg[5] && white_reg[6])
            || (mid && (white_reg[0] || white_reg[1]))
            || (mid && (white_reg[10] || white_reg[11]))
            || (cnt_reg == 2'd3) || (cnt_reg == 2'd2 && mid);
        rem_sh  = {rem_reg[15:0], num_reg[52]};
        rem_try = {1'b0, rem_sh} - {2'b0, fsum_reg};
        if (quo_reg[52:31] != '0)
            sat_mag = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (neg_reg && quo_reg[31])
            sat_mag = 32'h8000_0000;
        else
            sat_mag = quo_reg[31:0];
        derr  = 33'(err_reg) - 33'(prev_err_reg);
        mul_p = 56'(err_reg) * $signed({40'd0, kp_reg});
        mul_d = 56'(derr) * $signed({40'd0, kd_reg});
        corr_div = acc_reg[55] ? -((-acc_reg) >>> 24) : (acc_reg >>> 24);
        corr_lim = 32'(corr_div);
        if (mode_reg == lsps_pkg::MODE_LIMITED)
        begin
            if (corr_div > $signed(56'(limit_reg)))
                corr_lim = 32'(limit_reg);
            else if (corr_div < -$signed(56'(limit_reg)))
                corr_lim = -32'(limit_reg);
        end
        // Constant divisions by 10 and 100 are done by reciprocal multiplication.
        cap_n10  = mode_reg[1] ? {4'd0, speed_reg} * 12'd15 : {4'd0, speed_reg} * 12'd16;
        cap_n100 = {8'd0, speed_reg} * 16'd135;
        cap_p10  = {16'd0, cap_n10} * 28'd52429;
        cap_p100 = {12'd0, cap_n100} * 28'd5243;
        if (!mode_reg[1] && speed_reg > 8'd125)
            cap = {2'd0, cap_p100[27:19]};
        else
            cap = {2'd0, cap_p10[27:19]};
        rs = mode_reg[1] ? 34'(speed_reg) + 34'(corr_reg) : 34'(speed_reg) - 34'(corr_reg);
        ls = mode_reg[1] ? 34'(speed_reg) - 34'(corr_reg) : 34'(speed_reg) + 34'(corr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept && channel < 4'(lsps_pkg::CHANNELS))
        begin
            if (opcode == lsps_pkg::OP_LOAD)
            begin
                line_mem[channel]  <= line_threshold;
                white_mem[channel] <= white_threshold;
                green_mem[channel] <= green_threshold;
            end
            else
            begin
                raw_mem[channel]  <= raw_reading;
                filt_mem[channel] <= filtered_reading;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            limit_reg    <= 8'd20;
            scale_reg    <= 16'd3000;
            prev_err_reg <= '0;
            done         <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == lsps_pkg::CFG_LIMIT)
                    limit_reg <= cfg_data[7:0];
                else
                    scale_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && opcode == lsps_pkg::OP_SAMPLE && channel == 4'd11)
                    begin
                        state_reg <= S_WALK;
                        ch_reg    <= '0;
                        speed_reg <= base_speed;
                        mode_reg  <= steer_mode;
                        kp_reg    <= prop_gain;
                        kd_reg    <= deriv_gain;
                        gsum_reg  <= '0;
                        fsum_reg  <= '0;
                        cnt_reg   <= '0;
                        allg_reg  <= 1'b1;
                    end
                end
                S_WALK:
                begin
                    gsum_reg <= gsum_reg + prod_w;
                    fsum_reg <= fsum_reg + 16'(rd_filt);
                    if (rd_filt > rd_line && cnt_reg != 2'd3)
                        cnt_reg <= cnt_reg + 2'd1;
                    white_reg[ch_reg] <= rd_raw > rd_white;
                    if (ch_reg >= 4'd1 && ch_reg <= 4'd10 && !(rd_raw < rd_green))
                        allg_reg <= 1'b0;
                    ch_reg <= ch_reg + 4'd1;
                    if (ch_reg == 4'd11)
                        state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    neg_reg  <= gsum_reg[19];
                    num_reg  <= 53'({(gsum_reg[19] ? 19'(-gsum_reg) : 19'(gsum_reg))}
                                * {scale_reg, 8'd0});
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    step_reg <= '0;
                    if ((!mode_reg[1] && zeroed) || fsum_reg == '0)
                    begin
                        err_reg   <= '0;
                        state_reg <= S_MULP;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[51:0], 1'b0};
                    if (!rem_try[17])
                    begin
                        rem_reg <= rem_try[16:0];
                        quo_reg <= {quo_reg[51:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[51:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd52)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    err_reg   <= neg_reg ? -$signed(sat_mag) : $signed(sat_mag);
                    state_reg <= S_MULP;
                end
                S_MULP:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_MULD;
                end
                S_MULD:
                begin
                    acc_reg   <= acc_reg + mul_d;
                    state_reg <= S_CORR;
                end
                S_CORR:
                begin
                    corr_reg     <= corr_lim;
                    prev_err_reg <= err_reg;
                    state_reg    <= S_IDLE;
                    done         <= 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        busy = state_reg != S_IDLE;
        steer_error = prev_err_reg;
        right_speed = rs < 0 ? 9'd0 : (rs > 34'(cap) ? 9'(cap) : 9'(rs));
        left_speed  = ls < 0 ? 9'd0 : (ls > 34'(cap) ? 9'(cap) : 9'(ls));
    end
endmodule

// ----- rtl/lsps_checker.sv -----
// Port checker for the line sensor steering block, bound to the top level.
// Depends on lsps_pkg for codes.
module lsps_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic opcode,
    input logic [3:0] channel,
    input logic done,
    input logic [8:0] right_speed,
    input logic [8:0] left_speed
);
    // A final-channel sample transaction makes the block busy.
    a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == lsps_pkg::OP_SAMPLE && channel == 4'd11 |=> busy)
        else $error("final sample did not start evaluation");
    // Loads never make the block busy.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == lsps_pkg::OP_LOAD |=> !busy)
        else $error("load made block busy");
    // The result strobe ends the busy period.
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("strobe outside end of evaluation");
    // Strobes are single-cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("strobe longer than one cycle");
    // At the result strobe, speeds never exceed 408, which lies above the largest cap of 382.
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> right_speed <= 9'd408 && left_speed <= 9'd408)
        else $error("speed above cap");
endmodule

bind line_sensor_pd_steering_top lsps_checker u_lsps_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
    .channel(channel), .done(done), .right_speed(right_speed), .left_speed(left_speed)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for line_sensor_pd_steering_top: threshold loads, sample frames,
// register settings and random traffic, with a built-in steering predictor.
// Depends on lsps_pkg and the top level of the block only.
module testbench;
    typedef struct {
        logic        op;
        logic [3:0]  ch;
        logic [11:0] raw;
        logic [11:0] filt;
        logic [11:0] lthr;
        logic [11:0] wthr;
        logic [11:0] gthr;
        logic [7:0]  speed;
        logic [1:0]  mode;
        logic [15:0] kp;
        logic [15:0] kd;
    } sensor_item_t;

    typedef struct {
        logic [8:0]         right;
        logic [8:0]         left;
        logic signed [31:0] err;
    } wheel_cmd_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 120;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [3:0]  channel;
    logic [11:0] raw_reading;
    logic [11:0] filtered_reading;
    logic [11:0] line_threshold;
    logic [11:0] white_threshold;
    logic [11:0] green_threshold;
    logic [7:0]  base_speed;
    logic [1:0]  steer_mode;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic [8:0]  right_speed;
    logic [8:0]  left_speed;
    logic signed [31:0] steer_error;

    line_sensor_pd_steering_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .channel(channel), .raw_reading(raw_reading),
        .filtered_reading(filtered_reading), .line_threshold(line_threshold),
        .white_threshold(white_threshold), .green_threshold(green_threshold),
        .base_speed(base_speed), .steer_mode(steer_mode), .prop_gain(prop_gain),
        .deriv_gain(deriv_gain), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .right_speed(right_speed),
        .left_speed(left_speed), .steer_error(steer_error)
    );

    // Predictor state.
    logic [11:0] line_thr [lsps_pkg::CHANNELS];
    logic [11:0] white_thr [lsps_pkg::CHANNELS];
    logic [11:0] green_thr [lsps_pkg::CHANNELS];
    logic [11:0] raw_buf [lsps_pkg::CHANNELS];
    logic [11:0] filt_buf [lsps_pkg::CHANNELS];
    longint      last_error;
    int          limit_reg;
    int          scale_reg;

    int w_trace [lsps_pkg::CHANNELS]  = '{3, 5, 4, 3, 2, 1, -1, -2, -3, -4, -5, -3};
    int w_bridge_a [lsps_pkg::CHANNELS] = '{1, 2, 3, 4, 5, 6, -6, -5, -4, -3, -2, -1};
    int w_bridge_b [lsps_pkg::CHANNELS] = '{2, 2, 2, 2, 3, 3, -3, -3, -2, -2, -2, -2};

    wheel_cmd_t expected_cmds[$];
    int errors;
    int items_sent;
    int cmds_checked;
    int idle_cycles;
    bit no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit is_white(int i);
        return raw_buf[i] > white_thr[i];
    endfunction

    function automatic bit frame_zeroed();
        int cnt;
        bit all_white;
        bit all_green;
        bit mid;
        cnt = 0;
        all_white = 1'b1;
        all_green = 1'b1;
        for (int i = 0; i < lsps_pkg::CHANNELS; i++)
        begin
            if (filt_buf[i] > line_thr[i])
                cnt++;
        end
        for (int i = 1; i <= 10; i++)
        begin
            if (!is_white(i))
                all_white = 1'b0;
            if (!(raw_buf[i] < green_thr[i]))
                all_green = 1'b0;
        end
        mid = is_white(5) || is_white(6);
        if (all_white || all_green)
            return 1'b1;
        if (is_white(5) && is_white(6))
            return 1'b1;
        if (mid && (is_white(0) || is_white(1) || is_white(10) || is_white(11)))
            return 1'b1;
        return (cnt >= 3) || (cnt >= 2 && mid);
    endfunction

    task automatic predict_steering(input sensor_item_t it);
        longint gsum;
        longint fsum;
        longint err;
        longint corr;
        longint rs;
        longint ls;
        longint cap;
        int w;
        bit bridge;
        wheel_cmd_t cmd;
        if (it.ch >= lsps_pkg::CHANNELS)
            return;
        if (it.op == lsps_pkg::OP_LOAD)
        begin
            line_thr[it.ch] = it.lthr;
            white_thr[it.ch] = it.wthr;
            green_thr[it.ch] = it.gthr;
            return;
        end
        raw_buf[it.ch] = it.raw;
        filt_buf[it.ch] = it.filt;
        if (it.ch != lsps_pkg::CHANNELS - 1)
            return;
        bridge = (it.mode == lsps_pkg::MODE_BRIDGE_A) || (it.mode == lsps_pkg::MODE_BRIDGE_B);
        gsum = 0;
        fsum = 0;
        for (int i = 0; i < lsps_pkg::CHANNELS; i++)
        begin
            w = (it.mode == lsps_pkg::MODE_BRIDGE_A) ? w_bridge_a[i] :
                (it.mode == lsps_pkg::MODE_BRIDGE_B) ? w_bridge_b[i] : w_trace[i];
            fsum += longint'(filt_buf[i]);
            gsum += longint'(w) * longint'(raw_buf[i]);
        end
        err = 0;
        if ((bridge || !frame_zeroed()) && fsum != 0)
        begin
            err = (gsum * longint'(scale_reg) * 256) / fsum;
            if (err > 64'sd2147483647)
                err = 64'sd2147483647;
            if (err < -64'sd2147483648)
                err = -64'sd2147483648;
        end
        corr = (longint'(it.kp) * err + longint'(it.kd) * (err - last_error)) / 16777216;
        if (it.mode == lsps_pkg::MODE_LIMITED)
        begin
            if (corr > longint'(limit_reg))
                corr = longint'(limit_reg);
            if (corr < -longint'(limit_reg))
                corr = -longint'(limit_reg);
        end
        last_error = err;
        if (bridge)
        begin
            rs = longint'(it.speed) + corr;
            ls = longint'(it.speed) - corr;
            cap = (15 * longint'(it.speed)) / 10;
        end
        else
        begin
            rs = longint'(it.speed) - corr;
            ls = longint'(it.speed) + corr;
            cap = (it.speed <= 125) ? (16 * longint'(it.speed)) / 10
                                    : (135 * longint'(it.speed)) / 100;
        end
        rs = (rs < 0) ? 0 : ((rs > cap) ? cap : rs);
        ls = (ls < 0) ? 0 : ((ls > cap) ? cap : ls);
        cmd.right = rs[8:0];
        cmd.left = ls[8:0];
        cmd.err = err[31:0];
        expected_cmds.push_back(cmd);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic sensor_item_t random_item(logic op, logic [3:0] ch);
        sensor_item_t it;
        it.op = op;
        it.ch = ch;
        it.raw = 12'($urandom_range(0, 4095));
        it.filt = 12'($urandom_range(0, 4095));
        it.lthr = 12'($urandom_range(0, 4095));
        it.wthr = 12'($urandom_range(0, 4095));
        it.gthr = 12'($urandom_range(0, 4095));
        it.speed = 8'($urandom_range(0, 255));
        it.mode = 2'($urandom_range(0, 3));
        it.kp = 16'($urandom_range(0, 65535));
        it.kd = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    task automatic send_item(input sensor_item_t it);
        @(negedge clk);
        if (!no_gaps && $urandom_range(0, 99) < 30)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        opcode = it.op;
        channel = it.ch;
        raw_reading = it.raw;
        filtered_reading = it.filt;
        line_threshold = it.lthr;
        white_threshold = it.wthr;
        green_threshold = it.gthr;
        base_speed = it.speed;
        steer_mode = it.mode;
        prop_gain = it.kp;
        deriv_gain = it.kd;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        predict_steering(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == lsps_pkg::CFG_LIMIT)
            limit_reg = int'(value[7:0]);
        else
            scale_reg = int'(value);
    endtask

    // profile 0 random; any other profile gives high line and white thresholds and low green ones
    task automatic load_thresholds(input int profile);
        sensor_item_t it;
        for (int c = 0; c < lsps_pkg::CHANNELS; c++)
        begin
            it = random_item(lsps_pkg::OP_LOAD, 4'(c));
            if (profile != 0)
            begin
                it.lthr = 12'($urandom_range(2800, 4095));
                it.wthr = 12'($urandom_range(2400, 4095));
                it.gthr = 12'($urandom_range(0, 250));
            end
            send_item(it);
        end
    endtask

    task automatic send_frame(input int profile);
        sensor_item_t it;
        for (int c = 0; c < lsps_pkg::CHANNELS; c++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(random_item(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15))));
            it = random_item(lsps_pkg::OP_SAMPLE, 4'(c));
            case (profile)
                1:
                begin
                    it.raw = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(2500, 4095))
                                                         : 12'($urandom_range(300, 2400));
                    it.filt = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(2900, 4095))
                                                          : 12'($urandom_range(0, 2800));
                end
                2: it.raw = 12'($urandom_range(0, 200));
                3: it.raw = 12'($urandom_range(3000, 4095));
                default: ;
            endcase
            send_item(it);
        end
    endtask

    task automatic test_first_frame();
        sensor_item_t it;
        for (int c = 0; c < lsps_pkg::CHANNELS; c++)
        begin
            it = random_item(lsps_pkg::OP_LOAD, 4'(c));
            it.lthr = (c % 2) ? 12'hfff : 12'h000;
            it.wthr = (c % 2) ? 12'h000 : 12'hfff;
            send_item(it);
        end
        for (int c = 0; c < lsps_pkg::CHANNELS; c++)
        begin
            it = random_item(lsps_pkg::OP_SAMPLE, 4'(c));
            it.raw = (c % 2) ? 12'hfff : 12'h000;
            it.filt = 12'h000;
            send_item(it);
        end
    endtask

    task automatic test_last_channel_modes();
        sensor_item_t it;
        for (int m = 0; m < 4; m++)
        begin
            it = random_item(lsps_pkg::OP_SAMPLE, 4'(lsps_pkg::CHANNELS - 1));
            it.mode = 2'(m);
            it.speed = (m % 2) ? 8'hff : 8'h00;
            it.filt = (m == 0) ? 12'h000 : 12'hfff;
            it.kp = (m % 2) ? 16'hffff : 16'h0000;
            it.kd = (m % 2) ? 16'h0000 : 16'hffff;
            send_item(it);
        end
        it = random_item(lsps_pkg::OP_SAMPLE, 4'(lsps_pkg::CHANNELS - 1));
        it.speed = 8'd125;
        it.mode = lsps_pkg::MODE_TRACE;
        send_item(it);
        it.speed = 8'd126;
        send_item(it);
    endtask

    task automatic test_ignored_items();
        for (int c = lsps_pkg::CHANNELS; c < 16; c++)
            send_item(random_item(1'($urandom_range(0, 1)), 4'(c)));
        send_item(random_item(lsps_pkg::OP_LOAD, 4'(lsps_pkg::CHANNELS - 1)));
    endtask

    task automatic test_register_extremes();
        sensor_item_t it;
        logic [15:0] limits [3] = '{16'd0, 16'd255, 16'd20};
        logic [15:0] scales [3] = '{16'd0, 16'd1, 16'hffff};
        for (int k = 0; k < 3; k++)
        begin
            write_register(lsps_pkg::CFG_LIMIT, limits[k]);
            write_register(lsps_pkg::CFG_SCALE, scales[k]);
            for (int m = 0; m < 4; m++)
            begin
                it = random_item(lsps_pkg::OP_SAMPLE, 4'(lsps_pkg::CHANNELS - 1));
                it.mode = 2'(m);
                send_item(it);
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 7; phase++)
        begin
            write_register(lsps_pkg::CFG_LIMIT, 16'($urandom_range(0, 255)));
            write_register(lsps_pkg::CFG_SCALE,
                           (phase == 6) ? 16'd3000 : 16'($urandom_range(1, 65535)));
            no_gaps = (phase == 3);
            for (int f = 0; f < 11; f++)
            begin
                if (f % 4 == 0)
                    load_thresholds(($urandom_range(0, 3) == 0) ? 0 : 1);
                send_frame(($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 3));
            end
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_cmds.size() == 0)
            begin
                report_mismatch("result with none outstanding, right_speed",
                                longint'(right_speed), 64'sd0);
            end
            else
            begin
                wheel_cmd_t want;
                want = expected_cmds.pop_front();
                if (right_speed !== want.right)
                    report_mismatch("right_speed", longint'(right_speed), longint'(want.right));
                if (left_speed !== want.left)
                    report_mismatch("left_speed", longint'(left_speed), longint'(want.left));
                if (steer_error !== want.err)
                    report_mismatch("steer_error", longint'(steer_error), longint'(want.err));
                cmds_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        opcode = 1'b0;
        channel = 4'd0;
        raw_reading = 12'd0;
        filtered_reading = 12'd0;
        line_threshold = 12'd0;
        white_threshold = 12'd0;
        green_threshold = 12'd0;
        base_speed = 8'd0;
        steer_mode = lsps_pkg::MODE_TRACE;
        prop_gain = 16'd0;
        deriv_gain = 16'd0;
        cfg_we = 1'b0;
        cfg_index = lsps_pkg::CFG_LIMIT;
        cfg_data = 16'd0;
        errors = 0;
        items_sent = 0;
        cmds_checked = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        last_error = 0;
        limit_reg = 20;
        scale_reg = 3000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_frame();
        test_last_channel_modes();
        test_ignored_items();
        test_register_extremes();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d transactions and checked %0d steering results", items_sent,
                 cmds_checked);
        $display("Covered all four steering modes, register extremes and random frames");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/lsps_pkg.sv
rtl/line_sensor_pd_steering_top.sv
rtl/lsps_checker.sv
sim/testbench.sv
